[hw/rtl/pidsc_pkg.sv]
// Shared types, constants and register codes for the PID speed controller.
package pidsc_pkg;

   // Number of motor channels with their own loop state.
   localparam int CHANNELS = 4;
   localparam int CHANNEL_W = 2;

   // Field widths.
   localparam int SPEED_W = 16;
   localparam int DRIVE_W = 9;
   localparam int GAIN_W = 16;
   localparam int LIMIT_W = 8;
   localparam int SUM_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Register reset values: the gains are unsigned Q0.16.
   localparam logic [GAIN_W-1:0] KP_RESET = 16'd590;
   localparam logic [GAIN_W-1:0] KI_RESET = 16'd34;
   localparam logic [GAIN_W-1:0] KD_RESET = 16'd2477;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd255;

   // Manual drive floor, so that the drive stays symmetric.
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -9'sd255;

   // Control register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP_GAIN     = 2'd0,
      CSR_KI_GAIN     = 2'd1,
      CSR_KD_GAIN     = 2'd2,
      CSR_DRIVE_LIMIT = 2'd3
   } csr_index_type;

   // Loop mode codes.
   typedef enum logic {
      MODE_MANUAL = 1'b0,
      MODE_PID    = 1'b1
   } mode_type;

   // Loop state kept for one channel.
   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic signed [SPEED_W-1:0] prev_err;
      logic signed [SUM_W-1:0]   err_sum;
   } chan_state_type;

   // Gains and clamp as held in the control registers.
   typedef struct packed {
      logic [GAIN_W-1:0]  kp;
      logic [GAIN_W-1:0]  ki;
      logic [GAIN_W-1:0]  kd;
      logic [LIMIT_W-1:0] limit;
   } gains_type;

endpackage

[hw/rtl/pidsc_csr.sv]
// Control registers of the PID speed controller: gains and drive clamp.
module pidsc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pidsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pidsc_pkg::CSR_DATA_W-1:0]   csr_data,
   output pidsc_pkg::gains_type               gains
);
   import pidsc_pkg::*;

   gains_type gains_ff;
   gains_type gains_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the register index of a write beat.
   always_comb begin
      gains_in = gains_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_KP_GAIN:     gains_in.kp = csr_data;
            CSR_KI_GAIN:     gains_in.ki = csr_data;
            CSR_KD_GAIN:     gains_in.kd = csr_data;
            CSR_DRIVE_LIMIT: gains_in.limit = csr_data[LIMIT_W-1:0];
            default:         gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp <= KP_RESET;
         gains_ff.ki <= KI_RESET;
         gains_ff.kd <= KD_RESET;
         gains_ff.limit <= LIMIT_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule

[hw/rtl/pidsc_state.sv]
// Per-channel loop state registers with one read and one write port.
module pidsc_state (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pidsc_pkg::CHANNEL_W-1:0]   rd_channel,
   output pidsc_pkg::chan_state_type         rd_state,
   input  logic                              wr_enable,
   input  logic [pidsc_pkg::CHANNEL_W-1:0]   wr_channel,
   input  pidsc_pkg::chan_state_type         wr_state
);
   import pidsc_pkg::*;

   chan_state_type state_ff [CHANNELS];

   // The state of the channel at the compute stage.
   assign rd_state = state_ff[rd_channel];

   // Every channel starts with zero drive, error and error sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            state_ff[i] <= '0;
         end
      end else if (wr_enable) begin
         state_ff[wr_channel] <= wr_state;
      end
   end

endmodule

[hw/rtl/pidsc_datapath.sv]
// Combinational loop update for one control tick of one channel.
module pidsc_datapath (
   input  logic                                     mode,
   input  logic signed [pidsc_pkg::SPEED_W-1:0]     target_speed,
   input  logic signed [pidsc_pkg::SPEED_W-1:0]     measured_speed,
   input  logic signed [pidsc_pkg::DRIVE_W-1:0]     manual_drive,
   input  pidsc_pkg::gains_type                     gains,
   input  pidsc_pkg::chan_state_type                cur_state,
   output pidsc_pkg::chan_state_type                next_state
);
   import pidsc_pkg::*;

   localparam int DIFF_W = SPEED_W + 1;
   localparam int PKD_W = GAIN_W + 1 + DIFF_W;
   localparam int PI_W = GAIN_W + 1 + SUM_W;
   localparam int TOT_W = PI_W + 3;
   localparam int FRAC_W = 16;
   localparam int QUO_W = TOT_W - FRAC_W;

   logic signed [SPEED_W-1:0]  err;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [SUM_W-1:0]    sum_sat;
   logic signed [DIFF_W-1:0]   err_diff;
   logic signed [GAIN_W:0]     kp_s;
   logic signed [GAIN_W:0]     ki_s;
   logic signed [GAIN_W:0]     kd_s;
   logic signed [PKD_W-1:0]    p_kp;
   logic signed [PI_W-1:0]     p_ki;
   logic signed [PKD_W-1:0]    p_kd;
   logic signed [TOT_W-1:0]    drive_scaled;
   logic signed [TOT_W-1:0]    total;
   logic signed [QUO_W-1:0]    quo_floor;
   logic signed [QUO_W-1:0]    quo;
   logic signed [QUO_W-1:0]    lim_pos;
   logic signed [QUO_W-1:0]    lim_neg;
   logic signed [QUO_W-1:0]    clamped;
   logic signed [DRIVE_W-1:0]  manual_sat;

   // Error wraps to the speed width; the error sum saturates.
   assign err = target_speed - measured_speed;
   assign sum_wide = (SUM_W+1)'(cur_state.err_sum) + (SUM_W+1)'(err);
   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                   : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end
   assign err_diff = DIFF_W'(err) - DIFF_W'(cur_state.prev_err);

   // Three products of the unsigned gains with signed terms.
   assign kp_s = $signed({1'b0, gains.kp});
   assign ki_s = $signed({1'b0, gains.ki});
   assign kd_s = $signed({1'b0, gains.kd});
   assign p_kp = PKD_W'(kp_s) * PKD_W'(err);
   assign p_ki = PI_W'(ki_s) * PI_W'(sum_sat);
   assign p_kd = PKD_W'(kd_s) * PKD_W'(err_diff);

   // Drive in Q.16 plus the correction, then divide rounding toward zero.
   assign drive_scaled = $signed({(TOT_W-FRAC_W)'(cur_state.drive), {FRAC_W{1'b0}}});
   assign total = drive_scaled + TOT_W'(p_kp) + TOT_W'(p_ki) + TOT_W'(p_kd);
   assign quo_floor = total[TOT_W-1:FRAC_W];
   assign quo = (total[TOT_W-1] && (total[FRAC_W-1:0] != '0)) ? quo_floor + QUO_W'(1)
                                                               : quo_floor;

   // Symmetric clamp on the drive magnitude.
   assign lim_pos = $signed({(QUO_W-LIMIT_W)'(0), gains.limit});
   assign lim_neg = -lim_pos;
   always_comb begin
      if (quo > lim_pos) begin
         clamped = lim_pos;
      end else if (quo < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = quo;
      end
   end

   // The most negative manual code is pulled up to the symmetric floor.
   assign manual_sat = (manual_drive < DRIVE_MIN) ? DRIVE_MIN : manual_drive;

   // Select the new channel state by mode and target.
   always_comb begin
      next_state = cur_state;
      if (mode_type'(mode) == MODE_MANUAL) begin
         next_state.drive = manual_sat;
      end else if (target_speed == '0) begin
         next_state = '0;
      end else begin
         next_state.drive = clamped[DRIVE_W-1:0];
         next_state.prev_err = err;
         next_state.err_sum = sum_sat;
      end
   end

endmodule

[hw/rtl/pid_speed_controller.sv]
// PID speed controller: four-channel incremental speed loop, one tick per beat.
// Pipeline: a request beat is held in the input register while it is computed, and
// its new drive is loaded into the result register; a stalled result holds both.
// Throughput: one request beat per cycle while the result is not stalled; the channel
// state written by one tick is read by the tick after it, so ticks may follow back to back.
// Reset: synchronous, active high; clears channel state and both stage valids,
// and loads the gain and clamp registers with their defaults.
module pid_speed_controller (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [pidsc_pkg::CHANNEL_W-1:0]         req_channel,
   input  logic                                    req_mode,
   input  logic signed [pidsc_pkg::SPEED_W-1:0]    req_target_speed,
   input  logic signed [pidsc_pkg::SPEED_W-1:0]    req_measured_speed,
   input  logic signed [pidsc_pkg::DRIVE_W-1:0]    req_manual_drive,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [pidsc_pkg::CHANNEL_W-1:0]         rsp_out_channel,
   output logic signed [pidsc_pkg::DRIVE_W-1:0]    rsp_drive,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pidsc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pidsc_pkg::CSR_DATA_W-1:0]        csr_data
);
   import pidsc_pkg::*;

   logic                       in_valid_ff;
   logic [CHANNEL_W-1:0]       in_channel_ff;
   logic                       in_mode_ff;
   logic signed [SPEED_W-1:0]  in_target_ff;
   logic signed [SPEED_W-1:0]  in_measured_ff;
   logic signed [DRIVE_W-1:0]  in_manual_ff;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [CHANNEL_W-1:0]       out_channel_ff;
   logic signed [DRIVE_W-1:0]  out_drive_ff;
   logic signed [DRIVE_W-1:0]  out_drive_in;
   logic                       advance;
   logic                       take_req;
   logic                       chan_ok;
   gains_type                  gains;
   chan_state_type             cur_state;
   chan_state_type             next_state;

   // The compute stage moves when the result register is empty or drained.
   assign advance = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take_req = req_valid && !req_stall;
   assign chan_ok = (32'(in_channel_ff) < CHANNELS);

   pidsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .gains     (gains)
   );

   pidsc_state u_state (
      .clock      (clock),
      .reset      (reset),
      .rd_channel (in_channel_ff),
      .rd_state   (cur_state),
      .wr_enable  (in_valid_ff && advance && chan_ok),
      .wr_channel (in_channel_ff),
      .wr_state   (next_state)
   );

   pidsc_datapath u_datapath (
      .mode           (in_mode_ff),
      .target_speed   (in_target_ff),
      .measured_speed (in_measured_ff),
      .manual_drive   (in_manual_ff),
      .gains          (gains),
      .cur_state      (cur_state),
      .next_state     (next_state)
   );

   // Input register: holds the tick being computed.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance || !in_valid_ff) begin
         in_valid_ff <= take_req;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_channel_ff <= req_channel;
         in_mode_ff <= req_mode;
         in_target_ff <= req_target_speed;
         in_measured_ff <= req_measured_speed;
         in_manual_ff <= req_manual_drive;
      end
   end

   // Result register: loads the new drive of the computed tick.
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;
   assign out_drive_in = chan_ok ? next_state.drive : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_channel_ff <= in_channel_ff;
         out_drive_ff <= out_drive_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_out_channel = out_channel_ff;
   assign rsp_drive = out_drive_ff;

endmodule
